@@ hw/rtl/tbp_pkg.sv @@
`default_nettype none

package tbp_pkg;

    localparam int CTR_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index is paddr[2]
    localparam logic REG_COUNTER_MAX = 1'b0;

    localparam logic [CTR_W-1:0] COUNTER_MAX_RESET = 8'd3;

    typedef logic [CTR_W-1:0] ctr_t;

    typedef struct packed {
        ctr_t counter_max;
    } cfg_t;

    function automatic ctr_t sat_up(input ctr_t v, input ctr_t cmax);
        return (v < cmax) ? v + ctr_t'(1) : v;
    endfunction

    function automatic ctr_t sat_down(input ctr_t v);
        return (v != '0) ? v - ctr_t'(1) : '0;
    endfunction

    function automatic ctr_t train(input ctr_t v, input logic up, input ctr_t cmax);
        return up ? sat_up(v, cmax) : sat_down(v);
    endfunction

    function automatic logic above_half(input ctr_t v, input ctr_t cmax);
        return v > (cmax >> 1);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tournament_branch_predictor_top.sv @@
// Tournament branch predictor: gshare and per-address local history
// components, with a per-address chooser table.
// Input channel (in_valid/in_ready): opcode 0 predicts, opcode 1 predicts
// and then trains all tables with resolved_taken.
// Output channel (out_valid/out_ready): one result item per input item, in
// order, reporting the prediction as it stood before that item's training.
// Pipeline: out_valid rises after the table read, the local counter read and
// the result register. Throughput: one item per cycle unless the output stalls;
// read-after-write between neighboring items is resolved by forwarding from
// the write stage.
// counter_max is written through the APB port at byte address 0 and should
// only change while no item is in flight.
// Reset: the global history clears at once; the four tables are then zeroed
// by a sweep over all 2**INDEX_BITS entries, one entry per cycle, during which
// in_ready is low.
// Stall: while out_valid is held by a low out_ready, the result register
// keeps its item, a bubble in stage 2 is still filled, and in_ready drops
// once stage 2 holds an item.
`default_nettype none

module tournament_branch_predictor_top #(
    parameter int INDEX_BITS   = 10,
    parameter int HISTORY_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tbp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [tbp_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [tbp_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                   pready,
    // input items
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              opcode,
    input  wire logic [9:0]                        branch_address_low,
    input  wire logic                              resolved_taken,
    // result items
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   predicted_taken,
    output logic                                   global_taken,
    output logic                                   local_taken,
    output logic                                   chose_global
);
    import tbp_pkg::*;

    typedef logic [INDEX_BITS-1:0]   idx_t;
    typedef logic [HISTORY_BITS-1:0] hist_t;

    cfg_t cfg;

    tbp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // clearing sweep
    logic [INDEX_BITS:0] clr_cnt_reg, clr_cnt_next;
    logic                clearing;
    idx_t                clr_addr;

    assign clearing     = !clr_cnt_reg[INDEX_BITS];
    assign clr_addr     = clr_cnt_reg[INDEX_BITS-1:0];
    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    // flow control
    logic out_valid_reg, s1_valid_reg, s2_valid_reg;
    logic out_free, pipe_adv, accept;

    assign out_free = !out_valid_reg || out_ready;
    assign pipe_adv = out_free || !s2_valid_reg;
    assign in_ready = pipe_adv && !clearing;
    assign accept   = in_valid && in_ready;

    // global history advances at acceptance of a training item
    hist_t ghist_reg, ghist_next;
    idx_t  pc_in, gidx_in;

    assign pc_in      = INDEX_BITS'(branch_address_low);
    assign gidx_in    = pc_in ^ INDEX_BITS'(ghist_reg);
    assign ghist_next = (accept && opcode) ? HISTORY_BITS'({ghist_reg, resolved_taken})
                                           : ghist_reg;

    // stage 1 registers
    logic  s1_upd_reg, s1_taken_reg;
    idx_t  s1_pc_reg, s1_gidx_reg;
    logic  s1_lh_fwd_reg, s1_ch_fwd_reg, s1_gc_fwd_reg;
    hist_t s1_lh_fval_reg;
    ctr_t  s1_ch_fval_reg, s1_gc_fval_reg;

    // stage 2 registers
    logic  s2_upd_reg, s2_taken_reg;
    idx_t  s2_pc_reg, s2_gidx_reg, s2_lidx_reg;
    hist_t s2_lhist_reg;
    ctr_t  s2_ch_reg, s2_gc_reg;
    logic  s2_lc_fwd_reg;
    ctr_t  s2_lc_fval_reg;

    // table read data
    hist_t lh_q;
    ctr_t  ch_q, gc_q, lc_q;

    // stage 1 effective values
    hist_t lh_eff, lh_s1;
    ctr_t  ch_eff, gc_eff;
    idx_t  lidx_s1;

    assign lh_eff  = s1_lh_fwd_reg ? s1_lh_fval_reg : lh_q;
    assign ch_eff  = s1_ch_fwd_reg ? s1_ch_fval_reg : ch_q;
    assign gc_eff  = s1_gc_fwd_reg ? s1_gc_fval_reg : gc_q;

    // stage 2 compute and training
    ctr_t  lc_eff, gc_new, lc_new, ch_new;
    hist_t lh_new;
    logic  g_pred, l_pred, pick_g, final_pred, wr_en;

    assign lc_eff     = s2_lc_fwd_reg ? s2_lc_fval_reg : lc_q;
    assign g_pred     = above_half(s2_gc_reg, cfg.counter_max);
    assign l_pred     = above_half(lc_eff, cfg.counter_max);
    assign pick_g     = above_half(s2_ch_reg, cfg.counter_max);
    assign final_pred = pick_g ? g_pred : l_pred;

    assign gc_new = train(s2_gc_reg, s2_taken_reg, cfg.counter_max);
    assign lc_new = train(lc_eff, s2_taken_reg, cfg.counter_max);
    assign lh_new = HISTORY_BITS'({s2_lhist_reg, s2_taken_reg});
    assign ch_new = (g_pred != l_pred) ?
                    train(s2_ch_reg, g_pred == s2_taken_reg, cfg.counter_max) :
                    sat_down(s2_ch_reg);

    assign wr_en = s2_valid_reg && s2_upd_reg && out_free;

    // local history of the stage 1 item, including the write leaving stage 2
    assign lh_s1   = (wr_en && (s2_pc_reg == s1_pc_reg)) ? lh_new : lh_eff;
    assign lidx_s1 = INDEX_BITS'(lh_s1);

    // table write ports: sweep or training
    logic  tbl_we;
    idx_t  lh_waddr, ch_waddr, gc_waddr, lc_waddr;
    hist_t lh_wdata;
    ctr_t  ch_wdata, gc_wdata, lc_wdata;

    always_comb
    begin
        tbl_we   = wr_en;
        lh_waddr = s2_pc_reg;
        ch_waddr = s2_pc_reg;
        gc_waddr = s2_gidx_reg;
        lc_waddr = s2_lidx_reg;
        lh_wdata = lh_new;
        ch_wdata = ch_new;
        gc_wdata = gc_new;
        lc_wdata = lc_new;
        if (clearing)
        begin
            tbl_we   = 1'b1;
            lh_waddr = clr_addr;
            ch_waddr = clr_addr;
            gc_waddr = clr_addr;
            lc_waddr = clr_addr;
            lh_wdata = '0;
            ch_wdata = '0;
            gc_wdata = '0;
            lc_wdata = '0;
        end
    end

    tbp_ram #(.WIDTH(HISTORY_BITS), .ADDR_BITS(INDEX_BITS)) u_local_hist (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .re    (pipe_adv),
        .raddr (pc_in),
        .rdata (lh_q)
    );

    tbp_ram #(.WIDTH(CTR_W), .ADDR_BITS(INDEX_BITS)) u_chooser (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .re    (pipe_adv),
        .raddr (pc_in),
        .rdata (ch_q)
    );

    tbp_ram #(.WIDTH(CTR_W), .ADDR_BITS(INDEX_BITS)) u_global_ctr (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (gc_waddr),
        .wdata (gc_wdata),
        .re    (pipe_adv),
        .raddr (gidx_in),
        .rdata (gc_q)
    );

    tbp_ram #(.WIDTH(CTR_W), .ADDR_BITS(INDEX_BITS)) u_local_ctr (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (lc_waddr),
        .wdata (lc_wdata),
        .re    (pipe_adv),
        .raddr (lidx_s1),
        .rdata (lc_q)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            ghist_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            ghist_reg   <= ghist_next;
            if (pipe_adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers, with forwarding of the write in the same edge
    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            s1_upd_reg     <= opcode;
            s1_taken_reg   <= resolved_taken;
            s1_pc_reg      <= pc_in;
            s1_gidx_reg    <= gidx_in;
            s1_lh_fwd_reg  <= wr_en && (s2_pc_reg == pc_in);
            s1_ch_fwd_reg  <= wr_en && (s2_pc_reg == pc_in);
            s1_gc_fwd_reg  <= wr_en && (s2_gidx_reg == gidx_in);
            s1_lh_fval_reg <= lh_new;
            s1_ch_fval_reg <= ch_new;
            s1_gc_fval_reg <= gc_new;

            s2_upd_reg     <= s1_upd_reg;
            s2_taken_reg   <= s1_taken_reg;
            s2_pc_reg      <= s1_pc_reg;
            s2_gidx_reg    <= s1_gidx_reg;
            s2_lidx_reg    <= lidx_s1;
            s2_lhist_reg   <= lh_s1;
            s2_ch_reg      <= (wr_en && (s2_pc_reg == s1_pc_reg)) ? ch_new : ch_eff;
            s2_gc_reg      <= (wr_en && (s2_gidx_reg == s1_gidx_reg)) ? gc_new : gc_eff;
            s2_lc_fwd_reg  <= wr_en && (s2_lidx_reg == lidx_s1);
            s2_lc_fval_reg <= lc_new;
        end
        if (out_free)
        begin
            predicted_taken <= final_pred;
            global_taken    <= g_pred;
            local_taken     <= l_pred;
            chose_global    <= pick_g;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_no_write_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !wr_en && !s1_valid_reg && !s2_valid_reg
    ) else $error("training write or item in flight during table sweep");

    a_ghist_only_on_update: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$stable(ghist_reg) |-> $past(accept && opcode)
    ) else $error("global history changed without an accepted update");

    a_out_from_s2: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg)
    ) else $error("result appeared without an item in the last stage");

    a_s2_holds_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !pipe_adv |=> s2_valid_reg && $stable(s2_pc_reg)
                                      && $stable(s2_gidx_reg)
    ) else $error("last stage lost its item during a stall");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tbp_cfg_regs.sv @@
`default_nettype none

module tbp_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tbp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [tbp_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [tbp_pkg::CFG_DATA_W-1:0]    prdata,
    output tbp_pkg::cfg_t                          cfg
);
    import tbp_pkg::*;

    logic  wr_en;
    ctr_t  counter_max_reg;

    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_COUNTER_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_max_reg <= COUNTER_MAX_RESET;
        end
        else if (wr_en)
        begin
            counter_max_reg <= pwdata[CTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_COUNTER_MAX)
        begin
            prdata = CFG_DATA_W'(counter_max_reg);
        end
    end

    assign cfg.counter_max = counter_max_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tbp_ram.sv @@
`default_nettype none

module tbp_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_array [2**ADDR_BITS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
